// File: src/u2a_pkg.sv
// Shared types, constants and functions for the unsigned to ASCII radix converter.
`default_nettype none

package u2a_pkg;

   localparam int DEF_VALUE_WIDTH = 32;
   localparam int VALUE_BITS      = 32;
   localparam int CHAR_BITS       = 7;
   localparam int COUNT_BITS      = 4;

   localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
   localparam int          DEC_SHIFT = 35;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER = 7'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER = 7'h41;
   localparam logic [3:0]           DEC_RADIX  = 4'd10;

   typedef enum logic [1:0] {
      FMT_DEC    = 2'd0,
      FMT_OCT    = 2'd1,
      FMT_HEX_LO = 2'd2,
      FMT_HEX_UP = 2'd3
   } fmt_type;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic quot_zero;
      logic last_digit;
   } dp_stat_type;

   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [3:0] digit,
                                                          input logic       upper);
      logic [CHAR_BITS-1:0] base;
      base = upper ? CHAR_UPPER : CHAR_LOWER;
      if (digit >= DEC_RADIX) begin
         return CHAR_BITS'(digit) - CHAR_BITS'(DEC_RADIX) + base;
      end
      return CHAR_BITS'(digit) + CHAR_ZERO;
   endfunction

endpackage

`default_nettype wire

// File: src/u2a_if.sv
// Request and response channel interfaces of the radix converter.
`default_nettype none

interface u2a_req_if;
   import u2a_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [1:0]            action;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface u2a_rsp_if;
   import u2a_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CHAR_BITS-1:0]  ascii_char;
   logic                  last;
   logic [COUNT_BITS-1:0] char_count;

   modport source (output valid, output ascii_char, output last, output char_count,
                   input ready);
   modport sink   (input valid, input ascii_char, input last, input char_count,
                   output ready);
endinterface

`default_nettype wire

// File: src/u2a_ctrl.sv
// Controller state machine: load, digit extraction and digit emission.
`default_nettype none

module u2a_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic                  rsp_ready,
   output      logic                  rsp_valid,
   output      u2a_pkg::ctrl_cmd_type cmd,
   input  wire u2a_pkg::dp_stat_type  stat
);
   import u2a_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load = accept;
      cmd.step = (state_ff == ST_CONV);
      cmd.emit = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (stat.quot_zero) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cmd.emit && stat.last_digit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.emit}))
      else $error("controller issued overlapping commands");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && stat.last_digit) |=> (req_ready && rsp_valid))
      else $error("final digit did not return controller to idle");

   a_conv_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (cmd.step && !req_ready))
      else $error("load not followed by digit extraction");

endmodule

`default_nettype wire

// File: src/u2a_dp.sv
// Datapath: radix division step, digit buffer and response register.
`default_nettype none

module u2a_dp #(
   parameter int VALUE_WIDTH = u2a_pkg::DEF_VALUE_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire u2a_pkg::ctrl_cmd_type             cmd,
   output      u2a_pkg::dp_stat_type              stat,
   input  wire logic [1:0]                        req_action,
   input  wire logic [u2a_pkg::VALUE_BITS-1:0]    req_value,
   output      logic [u2a_pkg::CHAR_BITS-1:0]     rsp_ascii_char,
   output      logic                              rsp_last,
   output      logic [u2a_pkg::COUNT_BITS-1:0]    rsp_char_count
);
   import u2a_pkg::*;

   localparam int NUM_W  = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
   localparam int DIGITS = (NUM_W + 2) / 3;
   localparam int CNT_W  = $clog2(DIGITS + 1);
   localparam int IDX_W  = $clog2(DIGITS);

   logic [NUM_W-1:0]      num_ff, num_in;
   fmt_type               fmt_ff;
   logic [3:0]            digit_ff [DIGITS];
   logic [CNT_W-1:0]      wr_cnt_ff, wr_cnt_in;
   logic [CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic [CHAR_BITS-1:0]  char_ff;
   logic                  last_ff;
   logic [COUNT_BITS-1:0] count_ff;

   logic [31:0]      num_ext;
   logic [63:0]      prod;
   logic [NUM_W-1:0] quot;
   logic [3:0]       digit;
   logic [CNT_W-1:0] rd_idx;

   assign num_ext = 32'(num_ff);
   assign prod    = num_ext * DEC_RECIP;

   always_comb begin
      unique case (fmt_ff)
         FMT_DEC: begin
            quot  = NUM_W'(prod[63:DEC_SHIFT]);
            digit = num_ff[3:0] - ({quot[2:0], 1'b0} + {quot[0], 3'b000});
         end
         FMT_OCT: begin
            quot  = num_ff >> 3;
            digit = {1'b0, num_ff[2:0]};
         end
         FMT_HEX_LO, FMT_HEX_UP: begin
            quot  = num_ff >> 4;
            digit = num_ff[3:0];
         end
         default: begin
            quot  = '0;
            digit = '0;
         end
      endcase
   end

   assign rd_idx = rd_cnt_ff - CNT_W'(1);

   always_comb begin
      num_in    = num_ff;
      wr_cnt_in = wr_cnt_ff;
      rd_cnt_in = rd_cnt_ff;
      if (cmd.load) begin
         num_in    = req_value[NUM_W-1:0];
         wr_cnt_in = '0;
      end else if (cmd.step) begin
         num_in    = quot;
         wr_cnt_in = wr_cnt_ff + CNT_W'(1);
         rd_cnt_in = wr_cnt_ff + CNT_W'(1);
      end else if (cmd.emit) begin
         rd_cnt_in = rd_idx;
      end
   end

   always_comb begin
      stat.quot_zero  = (quot == '0);
      stat.last_digit = (rd_cnt_ff == CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_cnt_ff <= '0;
         rd_cnt_ff <= '0;
      end else begin
         wr_cnt_ff <= wr_cnt_in;
         rd_cnt_ff <= rd_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      if (cmd.load) begin
         fmt_ff <= fmt_type'(req_action);
      end
      if (cmd.step) begin
         digit_ff[wr_cnt_ff[IDX_W-1:0]] <= digit;
      end
      if (cmd.emit) begin
         char_ff  <= digit_to_ascii(digit_ff[rd_idx[IDX_W-1:0]], fmt_ff == FMT_HEX_UP);
         last_ff  <= stat.last_digit;
         count_ff <= stat.last_digit ? COUNT_BITS'(wr_cnt_ff) : '0;
      end
   end

   assign rsp_ascii_char = char_ff;
   assign rsp_last       = last_ff;
   assign rsp_char_count = count_ff;

   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (wr_cnt_ff < CNT_W'(DIGITS)))
      else $error("digit buffer overflow");

   a_emit_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (rd_cnt_ff != '0))
      else $error("emit with no digit pending");

   a_dec_digit: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && fmt_ff == FMT_DEC) |-> (digit < DEC_RADIX))
      else $error("decimal digit out of range");

   a_last_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && stat.last_digit) |=> (rsp_char_count != '0 && rsp_last))
      else $error("final transaction lacks character count");

endmodule

`default_nettype wire

// File: src/unsigned_to_ascii_radix.sv
// Top level of the unsigned to ASCII radix converter.
//
//   channel    dir  handshake      payload
//   req_chan   in   valid/ready    action[1:0], value[31:0]
//   rsp_chan   out  valid/ready    ascii_char[6:0], last, char_count[3:0]
//
// A number of N digits is converted in order: one load, one divide-by-radix step
// per digit in the shared divider step, then one digit out of the digit buffer per
// response transaction. Reset returns the controller to idle and empties the
// response register. A stalled response holds its transaction; the next request
// is taken once the final digit is loaded.
`default_nettype none

module unsigned_to_ascii_radix #(
   parameter int VALUE_WIDTH = u2a_pkg::DEF_VALUE_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   u2a_req_if.sink   req_chan,
   u2a_rsp_if.source rsp_chan
);
   import u2a_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   u2a_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   u2a_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_chan.action),
      .req_value      (req_chan.value),
      .rsp_ascii_char (rsp_chan.ascii_char),
      .rsp_last       (rsp_chan.last),
      .rsp_char_count (rsp_chan.char_count)
   );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for the unsigned to ASCII radix converter: directed and random numbers.
module tb;
   import u2a_pkg::*;

   typedef struct packed {
      logic [CHAR_BITS-1:0]  ascii_char;
      logic                  last;
      logic [COUNT_BITS-1:0] char_count;
   } digit_char_type;

   logic clock = 1'b0;
   logic reset;

   u2a_req_if req_chan ();
   u2a_rsp_if rsp_chan ();

   unsigned_to_ascii_radix u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   digit_char_type pending_digits[$];
   int             mismatch_count = 0;
   int             digits_checked = 0;
   int             numbers_sent   = 0;
   int             numbers_by_fmt [4];
   int             burst_left     = 0;
   logic [15:0]    stall_pattern;
   int             stall_phase    = 0;
   int             stall_mode     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Run did not finish in time");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic predict_digits(input fmt_type fmt, input logic [VALUE_BITS-1:0] num);
      logic [3:0]            digit_buf [0:15];
      int unsigned           radix;
      int unsigned           len;
      logic [VALUE_BITS-1:0] rest;
      logic [CHAR_BITS-1:0]  letter_base;
      digit_char_type        next_char;
      radix = (fmt == FMT_DEC) ? 10 : (fmt == FMT_OCT) ? 8 : 16;
      letter_base = (fmt == FMT_HEX_UP) ? CHAR_UPPER : CHAR_LOWER;
      rest = num;
      len = 0;
      do begin
         digit_buf[len] = 4'(rest % radix);
         rest = rest / radix;
         len++;
      end while (rest != 0);
      for (int k = len; k > 0; k--) begin
         if (digit_buf[k-1] > 4'd9) begin
            next_char.ascii_char = CHAR_BITS'(digit_buf[k-1]) - CHAR_BITS'(10) + letter_base;
         end else begin
            next_char.ascii_char = CHAR_BITS'(digit_buf[k-1]) + CHAR_ZERO;
         end
         next_char.last = (k == 1);
         next_char.char_count = (k == 1) ? COUNT_BITS'(len) : '0;
         pending_digits.push_back(next_char);
      end
   endtask

   // call at a falling edge; returns at the falling edge after the request handshake
   task automatic send_number(input fmt_type fmt, input logic [VALUE_BITS-1:0] num);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= fmt;
      req_chan.value  <= num;
      do @(posedge clock); while (!req_chan.ready);
      predict_digits(fmt, num);
      numbers_sent++;
      numbers_by_fmt[fmt]++;
      burst_left--;
      @(negedge clock);
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_phase == 0) begin
            stall_phase   = $urandom_range(20, 80);
            stall_mode    = $urandom_range(0, 2);
            stall_pattern = 16'($urandom);
         end
         stall_phase--;
         stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
         case (stall_mode)
            0: begin
               rsp_chan.ready <= 1'b1;
            end
            1: begin
               rsp_chan.ready <= stall_pattern[0];
            end
            default: begin
               rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      digit_char_type got;
      digit_char_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.ascii_char = rsp_chan.ascii_char;
         got.last       = rsp_chan.last;
         got.char_count = rsp_chan.char_count;
         if (pending_digits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected transaction: char %h last %b count %0d",
                        got.ascii_char, got.last, got.char_count);
            end
         end else begin
            want = pending_digits.pop_front();
            digits_checked++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display({"Digit %0d: expected char %h last %b count %0d, ",
                            "got char %h last %b count %0d"},
                           digits_checked, want.ascii_char, want.last, want.char_count,
                           got.ascii_char, got.last, got.char_count);
               end
            end
         end
      end
   end

   task automatic test_zero_values();
      send_number(FMT_DEC, '0);
      send_number(FMT_OCT, '0);
      send_number(FMT_HEX_LO, '0);
      send_number(FMT_HEX_UP, '0);
   endtask

   task automatic test_max_values();
      send_number(FMT_DEC, '1);
      send_number(FMT_OCT, '1);
      send_number(FMT_HEX_LO, '1);
      send_number(FMT_HEX_UP, '1);
   endtask

   task automatic test_digit_rollover();
      send_number(FMT_DEC, 32'd9);
      send_number(FMT_DEC, 32'd10);
      send_number(FMT_OCT, 32'd7);
      send_number(FMT_OCT, 32'd8);
      send_number(FMT_HEX_LO, 32'd15);
      send_number(FMT_HEX_UP, 32'd16);
      send_number(FMT_DEC, 32'd999_999_999);
      send_number(FMT_DEC, 32'd1_000_000_000);
      send_number(FMT_OCT, 32'h4000_0000);
      send_number(FMT_OCT, 32'h8000_0000);
   endtask

   task automatic test_letter_digits();
      send_number(FMT_HEX_LO, 32'hDEAD_BEEF);
      send_number(FMT_HEX_UP, 32'hDEAD_BEEF);
      send_number(FMT_HEX_UP, 32'hABCD_EF01);
      send_number(FMT_HEX_LO, 32'hFEDC_BA98);
   endtask

   task automatic test_random_numbers(input int count);
      logic [VALUE_BITS-1:0] num;
      fmt_type               fmt;
      repeat (count) begin
         fmt = fmt_type'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0: num = $urandom;
            1: num = $urandom >> $urandom_range(1, 31);
            2: num = $urandom_range(0, 20);
            3: num = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            4: num = 32'hFFFF_FFFF >> $urandom_range(0, 31);
            default: num = ~($urandom >> $urandom_range(0, 31));
         endcase
         send_number(fmt, num);
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.action = FMT_DEC;
      req_chan.value  = '0;
      foreach (numbers_by_fmt[i]) numbers_by_fmt[i] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_zero_values();
      test_max_values();
      test_digit_rollover();
      test_letter_digits();
      test_random_numbers(308);
      req_chan.valid <= 1'b0;

      while (pending_digits.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Converted %0d numbers into %0d checked digits", numbers_sent, digits_checked);
      $display("Formats: dec %0d, oct %0d, hex lower %0d, hex upper %0d; mismatches %0d",
               numbers_by_fmt[FMT_DEC], numbers_by_fmt[FMT_OCT],
               numbers_by_fmt[FMT_HEX_LO], numbers_by_fmt[FMT_HEX_UP], mismatch_count);
      if (mismatch_count == 0 && pending_digits.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
src/u2a_pkg.sv
src/u2a_if.sv
src/u2a_ctrl.sv
src/u2a_dp.sv
src/unsigned_to_ascii_radix.sv
tb/sv/tb.sv
